// File: hdl/dhrb_pkg.sv
// Shared types, register indexes and reset values for the dual H-bridge reversal brake.
package dhrb_pkg;

    localparam int DUTY_WIDTH_DEF = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME  = 2'd2;

    localparam logic [15:0] DUTY_LIMIT_RST = 16'd1000;
    localparam logic [15:0] FULL_DUTY_RST  = 16'd1000;
    localparam logic [7:0]  DEAD_TIME_RST  = 8'd2;

    // Direction codes kept per channel.
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    typedef struct packed {
        logic signed [15:0] speed_a;
        logic signed [15:0] speed_b;
    } t_in_item;

    typedef struct packed {
        logic [15:0] a_in1_duty;
        logic [15:0] a_in2_duty;
        logic [15:0] b_in1_duty;
        logic [15:0] b_in2_duty;
        logic        a_update;
        logic        b_update;
        logic [7:0]  hold_ms;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] duty_limit;
        logic [15:0] full_duty;
        logic [7:0]  dead_hold;
    } t_cfg;

endpackage

// File: hdl/dual_hbridge_reversal_brake_top.sv
// Top level of the dual H-bridge direction control with reversal brake.
// Each transfer on the input channel carries one signed speed per channel and yields one
// target result, preceded by a brake result with the dead-time hold when a channel flips
// direction. Items are registered on entry; results are built combinationally into an output
// register backed by a second slot for the target result. While results are taken, an item is
// taken every cycle without a reversal; with one, the next item waits while the target result
// is pending, as the port delivers one result per cycle. Results pass the input and output
// registers. Configuration is taken at any time and is meant to change only while idle.
module dual_hbridge_reversal_brake_top #(
    parameter int DUTY_WIDTH = dhrb_pkg::DUTY_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dhrb_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dhrb_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dhrb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dhrb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dhrb_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic [1:0] r_prev_sign_a;
    logic [1:0] r_prev_sign_b;
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_pend_valid;
    t_out_item r_pend;

    logic      brake;
    t_out_item brake_res;
    t_out_item target_res;
    logic [1:0] sign_a;
    logic [1:0] sign_b;
    logic      out_take;
    logic      move;

    dhrb_result #(
        .DUTY_WIDTH(DUTY_WIDTH)
    ) u_result (
        .i_item        (r_in),
        .i_cfg         (r_cfg),
        .i_prev_sign_a (r_prev_sign_a),
        .i_prev_sign_b (r_prev_sign_b),
        .o_brake       (brake),
        .o_brake_res   (brake_res),
        .o_target_res  (target_res),
        .o_sign_a      (sign_a),
        .o_sign_b      (sign_b)
    );

    assign out_take    = r_out_valid && i_out_ready;
    // The registered item moves on once both result slots will be free.
    assign move        = r_in_valid && (!r_out_valid || (out_take && !r_pend_valid));
    assign o_in_ready  = !r_in_valid || move;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_limit <= DUTY_LIMIT_RST;
            r_cfg.full_duty  <= FULL_DUTY_RST;
            r_cfg.dead_hold  <= DEAD_TIME_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DUTY_LIMIT: r_cfg.duty_limit <= i_cfg_data;
                REG_FULL_DUTY:  r_cfg.full_duty  <= i_cfg_data;
                REG_DEAD_TIME:  r_cfg.dead_hold  <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_prev_sign_a <= SIGN_ZERO;
            r_prev_sign_b <= SIGN_ZERO;
            r_out_valid   <= 1'b0;
            r_pend_valid  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (move) begin
                r_prev_sign_a <= sign_a;
                r_prev_sign_b <= sign_b;
                r_out_valid   <= 1'b1;
                r_pend_valid  <= brake;
            end else if (out_take) begin
                r_out_valid  <= r_pend_valid;
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (move) begin
            r_out  <= brake ? brake_res : target_res;
            r_pend <= target_res;
        end else if (out_take && r_pend_valid) begin
            r_out <= r_pend;
        end
    end

endmodule

// File: hdl/dhrb_result.sv
// Combinational result builder: signs, clamped duties, brake and target results.
module dhrb_result #(
    parameter int DUTY_WIDTH = dhrb_pkg::DUTY_WIDTH_DEF
) (
    input  dhrb_pkg::t_in_item  i_item,
    input  dhrb_pkg::t_cfg      i_cfg,
    input  logic [1:0]          i_prev_sign_a,
    input  logic [1:0]          i_prev_sign_b,
    output logic                o_brake,
    output dhrb_pkg::t_out_item o_brake_res,
    output dhrb_pkg::t_out_item o_target_res,
    output logic [1:0]          o_sign_a,
    output logic [1:0]          o_sign_b
);
    import dhrb_pkg::*;

    localparam int          MaskBits = (DUTY_WIDTH < 16) ? DUTY_WIDTH : 16;
    localparam logic [15:0] DutyMask = 16'((32'd1 << MaskBits) - 32'd1);

    logic [15:0] max_lim;
    logic [15:0] full;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic        rev_a;
    logic        rev_b;
    logic [15:0] a_in1, a_in2, b_in1, b_in2;

    function automatic logic [1:0] sign_of(input logic [15:0] v);
        if (v == 16'd0) begin
            return SIGN_ZERO;
        end
        return v[15] ? SIGN_NEG : SIGN_POS;
    endfunction

    function automatic logic [15:0] duty_of(input logic [15:0] v, input logic [15:0] lim);
        logic [16:0] ext;
        logic [16:0] mag;
        ext = {v[15], v};
        mag = v[15] ? (~ext + 17'd1) : ext;
        return (mag > {1'b0, lim}) ? lim : mag[15:0];
    endfunction

    function automatic logic reverses(input logic [1:0] prev, input logic [1:0] cur);
        return (prev != SIGN_ZERO) && (cur != SIGN_ZERO) && (prev != cur);
    endfunction

    assign max_lim  = i_cfg.duty_limit & DutyMask;
    assign full     = i_cfg.full_duty & DutyMask;
    assign o_sign_a = sign_of(i_item.speed_a);
    assign o_sign_b = sign_of(i_item.speed_b);
    assign duty_a   = duty_of(i_item.speed_a, max_lim);
    assign duty_b   = duty_of(i_item.speed_b, max_lim);
    assign rev_a    = reverses(i_prev_sign_a, o_sign_a);
    assign rev_b    = reverses(i_prev_sign_b, o_sign_b);
    assign o_brake  = rev_a || rev_b;

    // Zero speed brakes with full duty on both inputs of the bridge.
    always_comb begin
        unique case (o_sign_a)
            SIGN_ZERO: begin a_in1 = full;   a_in2 = full;   end
            SIGN_POS:  begin a_in1 = duty_a; a_in2 = 16'd0;  end
            default:   begin a_in1 = 16'd0;  a_in2 = duty_a; end
        endcase
        unique case (o_sign_b)
            SIGN_ZERO: begin b_in1 = full;   b_in2 = full;   end
            SIGN_POS:  begin b_in1 = duty_b; b_in2 = 16'd0;  end
            default:   begin b_in1 = 16'd0;  b_in2 = duty_b; end
        endcase
    end

    always_comb begin
        o_brake_res.a_in1_duty = rev_a ? full : 16'd0;
        o_brake_res.a_in2_duty = rev_a ? full : 16'd0;
        o_brake_res.b_in1_duty = rev_b ? full : 16'd0;
        o_brake_res.b_in2_duty = rev_b ? full : 16'd0;
        o_brake_res.a_update   = rev_a;
        o_brake_res.b_update   = rev_b;
        o_brake_res.hold_ms    = i_cfg.dead_hold;
        o_brake_res.last       = 1'b0;

        o_target_res.a_in1_duty = a_in1;
        o_target_res.a_in2_duty = a_in2;
        o_target_res.b_in1_duty = b_in1;
        o_target_res.b_in2_duty = b_in2;
        o_target_res.a_update   = 1'b1;
        o_target_res.b_update   = 1'b1;
        o_target_res.hold_ms    = 8'd0;
        o_target_res.last       = 1'b1;
    end

endmodule

// File: hdl/dhrb_checker.sv
// Port-level checker for the dual H-bridge reversal brake, bound to the top level.
module dhrb_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input dhrb_pkg::t_out_item                 o_out
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // A brake result is always followed at once by its target result.
    a_brake_then_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last |=> o_out_valid && o_out.last)
        else $error("brake result not followed by target result");

    // A brake result brakes at least one channel and leaves the others cleared.
    a_brake_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |->
            (o_out.a_update || o_out.b_update)
            && (o_out.a_update || (o_out.a_in1_duty == 16'd0 && o_out.a_in2_duty == 16'd0))
            && (o_out.b_update || (o_out.b_in1_duty == 16'd0 && o_out.b_in2_duty == 16'd0)))
        else $error("malformed brake result");

    // A target result updates both channels and carries no hold.
    a_target_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last |->
            o_out.a_update && o_out.b_update && (o_out.hold_ms == 8'd0))
        else $error("malformed target result");

endmodule

bind dual_hbridge_reversal_brake_top dhrb_checker u_dhrb_checker (.*);

// File: test/dhrb_duty_scoreboard_pkg.sv
// Scoreboard for the dual H-bridge reversal brake: predicts compare values and checks results.
package dhrb_duty_scoreboard_pkg;

    import dhrb_pkg::*;

    class duty_scoreboard;

        logic [15:0] duty_limit;
        logic [15:0] full_duty;
        logic [7:0]  dead_hold;
        logic [1:0]  dir_a;
        logic [1:0]  dir_b;
        t_out_item   expected_duties[$];
        int          failures;

        function new();
            duty_limit = DUTY_LIMIT_RST;
            full_duty  = FULL_DUTY_RST;
            dead_hold  = DEAD_TIME_RST;
            dir_a      = SIGN_ZERO;
            dir_b      = SIGN_ZERO;
            failures   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DUTY_LIMIT: begin
                    duty_limit = data;
                end
                REG_FULL_DUTY: begin
                    full_duty = data;
                end
                REG_DEAD_TIME: begin
                    dead_hold = data[7:0];
                end
                default: begin
                end
            endcase
        endfunction

        function logic [1:0] dir_of(logic signed [15:0] speed);
            if (speed == 0) return SIGN_ZERO;
            return speed[15] ? SIGN_NEG : SIGN_POS;
        endfunction

        // The most negative speed has a magnitude of 2^15, hence the extra bit.
        function logic [15:0] duty_of(logic signed [15:0] speed);
            logic [16:0] mag;
            mag = speed[15] ? 17'h10000 - {1'b0, speed} : {1'b0, speed};
            if (mag > {1'b0, duty_limit}) mag = {1'b0, duty_limit};
            return mag[15:0];
        endfunction

        function void drive_pair(logic [1:0] dir, logic [15:0] duty,
                                 output logic [15:0] in1, output logic [15:0] in2);
            case (dir)
                SIGN_ZERO: begin
                    in1 = full_duty;
                    in2 = full_duty;
                end
                SIGN_POS: begin
                    in1 = duty;
                    in2 = '0;
                end
                default: begin
                    in1 = '0;
                    in2 = duty;
                end
            endcase
        endfunction

        function void note_speed(t_in_item it);
            logic [1:0] new_a;
            logic [1:0] new_b;
            logic       flip_a;
            logic       flip_b;
            t_out_item  r;
            new_a  = dir_of(it.speed_a);
            new_b  = dir_of(it.speed_b);
            flip_a = dir_a != SIGN_ZERO && new_a != SIGN_ZERO && dir_a != new_a;
            flip_b = dir_b != SIGN_ZERO && new_b != SIGN_ZERO && dir_b != new_b;
            if (flip_a || flip_b) begin
                r.a_in1_duty = flip_a ? full_duty : '0;
                r.a_in2_duty = flip_a ? full_duty : '0;
                r.b_in1_duty = flip_b ? full_duty : '0;
                r.b_in2_duty = flip_b ? full_duty : '0;
                r.a_update   = flip_a;
                r.b_update   = flip_b;
                r.hold_ms    = dead_hold;
                r.last       = 1'b0;
                expected_duties.push_back(r);
            end
            drive_pair(new_a, duty_of(it.speed_a), r.a_in1_duty, r.a_in2_duty);
            drive_pair(new_b, duty_of(it.speed_b), r.b_in1_duty, r.b_in2_duty);
            r.a_update = 1'b1;
            r.b_update = 1'b1;
            r.hold_ms  = '0;
            r.last     = 1'b1;
            expected_duties.push_back(r);
            dir_a = new_a;
            dir_b = new_b;
        endfunction

        function string show(t_out_item r);
            return $sformatf("a=%0d/%0d b=%0d/%0d upd=%b%b hold=%0d last=%b",
                             r.a_in1_duty, r.a_in2_duty, r.b_in1_duty, r.b_in2_duty,
                             r.a_update, r.b_update, r.hold_ms, r.last);
        endfunction

        function void check_duty(t_out_item got);
            t_out_item want;
            string     bad;
            if (expected_duties.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result: %s", show(got));
                return;
            end
            want = expected_duties.pop_front();
            bad  = "";
            if (got.a_in1_duty !== want.a_in1_duty) bad = {bad, " a_in1_duty"};
            if (got.a_in2_duty !== want.a_in2_duty) bad = {bad, " a_in2_duty"};
            if (got.b_in1_duty !== want.b_in1_duty) bad = {bad, " b_in1_duty"};
            if (got.b_in2_duty !== want.b_in2_duty) bad = {bad, " b_in2_duty"};
            if (got.a_update !== want.a_update)     bad = {bad, " a_update"};
            if (got.b_update !== want.b_update)     bad = {bad, " b_update"};
            if (got.hold_ms !== want.hold_ms)       bad = {bad, " hold_ms"};
            if (got.last !== want.last)             bad = {bad, " last"};
            if (bad != "") begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch in%s: expected %s, got %s", bad, show(want), show(got));
                end
            end
        endfunction

        function int pending();
            return expected_duties.size();
        endfunction

    endclass

endpackage

// File: test/dual_hbridge_reversal_brake_top_test.sv
// Self-checking testbench for the dual H-bridge reversal brake top level.
module dual_hbridge_reversal_brake_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dhrb_pkg::*;
    import dhrb_duty_scoreboard_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 6;
    localparam int LIMIT_NS     = 8_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic send_steady = 1'b0;
    logic recv_steady = 1'b0;
    logic hold_req = 1'b0;

    duty_scoreboard sb = new();

    dual_hbridge_reversal_brake_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_speed(i_in);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_duty(o_out);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 94) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] rand_speed(int lim);
        int                 r;
        int                 m;
        logic signed [15:0] s;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            s = '0;
        end else if (r < 22) begin
            case ($urandom_range(0, 3))
                0: s = 16'sh8000;
                1: s = 16'sh7FFF;
                2: s = 16'sd1;
                default: s = -16'sd1;
            endcase
        end else if (r < 60) begin
            // Magnitudes around the clamp so both sides of it are hit.
            m = $urandom_range(1, (lim > 32000) ? 32767 : lim + 16);
            s = 16'(m);
            if ($urandom_range(0, 1) == 1) s = -s;
        end else begin
            s = 16'($urandom());
        end
        return s;
    endfunction

    function automatic logic [15:0] pick_duty_reg();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(1, 64));
            4, 5, 6, 7: return 16'($urandom_range(100, 4000));
            default: return 16'($urandom());
        endcase
    endfunction

    // The receiver: random ready bursts and gaps, a steady mode, and one long hold-off.
    initial begin : out_ready_gen
        int   run;
        logic level;
        run   = 0;
        level = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++) @(negedge i_clk);
                hold_req = 1'b0;
                run      = 0;
            end else if (recv_steady) begin
                i_out_ready <= 1'b1;
            end else begin
                if (run == 0) begin
                    level = ~level;
                    run   = level ? $urandom_range(1, 16) : idle_len();
                end
                i_out_ready <= level;
                run--;
            end
        end
    end

    task automatic send_speed(input logic signed [15:0] a, input logic signed [15:0] b);
        int       idle;
        t_in_item it;
        it.speed_a = a;
        it.speed_b = b;
        idle = (send_steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        for (int k = 0; k < idle; k++) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering, let every expected result arrive, then allow for the pipeline.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [15:0] md;
        logic [15:0] fd;
        logic [15:0] dt;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset settings.
        send_speed(16'sd0, 16'sd0);
        send_speed(16'sh7FFF, 16'sd1);
        send_speed(16'sh8000, -16'sd1);
        send_speed(-16'sd5, 16'sd300);
        send_speed(16'sd0, 16'sd300);
        send_speed(16'sd7, 16'sd0);
        send_speed(-16'sd7, -16'sd1000);
        send_speed(16'sd1000, 16'sd1001);
        send_speed(16'sd999, 16'sh8000);
        send_speed(-16'sd32767, 16'sh7FFF);
        send_speed(16'sh5555, -16'sh5556);
        send_speed(-16'sh5556, 16'sh5555);
        send_speed(16'sd0, 16'sd0);
        send_speed(-16'sd1, 16'sd1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    md = '0;
                    fd = 16'hFFFF;
                    dt = 16'hFFFF;
                end
                1: begin
                    md = 16'hFFFF;
                    fd = '0;
                    dt = 16'hFF00;
                end
                default: begin
                    md = pick_duty_reg();
                    fd = pick_duty_reg();
                    dt = 16'($urandom());
                end
            endcase
            write_reg(REG_DUTY_LIMIT, md);
            write_reg(REG_FULL_DUTY, fd);
            write_reg(REG_DEAD_TIME, dt);
            if (p == 1) write_reg(REG_SPARE, 16'($urandom()));

            send_steady = (p == 2 || p == 3);
            recv_steady = (p == 2);
            // One phase holds the output off long enough for the input to stall.
            if (p == 3) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_speed(rand_speed(int'(md)), rand_speed(int'(md)));
            end
            drain();
            send_steady = 1'b0;
            recv_steady = 1'b0;
        end

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("dual_hbridge_reversal_brake_top_test: PASS");
        end else begin
            $display("dual_hbridge_reversal_brake_top_test: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("dual_hbridge_reversal_brake_top_test: FAIL");
        $finish;
    end

endmodule
